@@ design/grbc_pkg.sv @@
package grbc_pkg;

    localparam int GYRO_W        = 16;
    localparam int TIME_W        = 32;
    localparam int CFG_DATA_W    = 32;
    localparam int CFG_INDEX_W   = 3;
    localparam int RING_DEPTH_DEF = 100;

    localparam logic [15:0] DECIMATE_RST = 16'd10;
    localparam logic [15:0] MOTION_RST   = 16'd10;
    localparam logic [15:0] RATE_RST     = 16'd80;
    localparam logic [31:0] REST_RST     = 32'd2000;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_DECIMATE = 3'd0,
        CFG_MOTION   = 3'd1,
        CFG_RATE     = 3'd2,
        CFG_REST     = 3'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [15:0] decimate_ms;
        logic [15:0] motion_limit;
        logic [15:0] rate_limit;
        logic [31:0] rest_time_ms;
    } cfg_t;

    typedef struct packed {
        logic signed [GYRO_W-1:0] x;
        logic signed [GYRO_W-1:0] y;
        logic signed [GYRO_W-1:0] z;
    } axes_t;

    typedef struct packed {
        axes_t              g;
        logic [TIME_W-1:0]  now;
    } sample_t;

    typedef struct packed {
        logic  sampled;
        logic  still;
        logic  calibrated;
        logic  capture;
        logic  take_ring;
        axes_t g;
    } decision_t;

    typedef struct packed {
        logic  sampled;
        logic  still;
        logic  calibrated;
        axes_t bias;
        axes_t rate;
    } result_t;

    // Magnitude of an axis value; -32768 comes out as 32768.
    function automatic logic [15:0] mag16(logic signed [15:0] v);
        logic [16:0] e;
        begin
            e = {v[15], v};
            if (v[15])
            begin
                e = -e;
            end
            return e[15:0];
        end
    endfunction

    // Magnitude of a difference of two axis values, at most 65535.
    function automatic logic [15:0] mag17(logic signed [16:0] v);
        logic [16:0] e;
        begin
            e = v;
            if (v[16])
            begin
                e = -e;
            end
            return e[15:0];
        end
    endfunction

endpackage

@@ design/grbc_ram.sv @@
module grbc_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 100,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/grbc_detect.sv @@
module grbc_detect
    import grbc_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF,
    localparam int IDX_W = $clog2(RING_DEPTH),
    localparam int CNT_W = $clog2(RING_DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             cfg,
    input  sample_t          smp,
    input  logic             fire,
    output decision_t        dec,
    output logic             ring_we,
    output logic [IDX_W-1:0] ring_waddr,
    output logic             ring_re,
    output logic [IDX_W-1:0] ring_raddr
);

    logic [TIME_W-1:0] last_accept_reg;
    logic [TIME_W-1:0] rest_start_reg;
    logic [TIME_W-1:0] rest_start_next;
    axes_t             prev_reg;
    logic              calibrated_reg;
    logic [IDX_W-1:0]  widx_reg;
    logic [IDX_W-1:0]  widx_next;
    logic [CNT_W-1:0]  fill_reg;

    logic [TIME_W-1:0] since_last;
    logic [TIME_W-1:0] rest_base;
    logic [TIME_W-1:0] rest_elapsed;
    logic              sampled;
    logic              still;
    logic              long_rest;
    logic              capture;
    logic              push;
    logic              full;
    logic signed [16:0] dx, dy, dz;
    logic [17:0]       motion_sum;
    logic [15:0]       motion;
    logic              rates_small;

    always_comb
    begin
        since_last = smp.now - last_accept_reg;
        sampled    = since_last >= {16'b0, cfg.decimate_ms};

        dx = {smp.g.x[15], smp.g.x} - {prev_reg.x[15], prev_reg.x};
        dy = {smp.g.y[15], smp.g.y} - {prev_reg.y[15], prev_reg.y};
        dz = {smp.g.z[15], smp.g.z} - {prev_reg.z[15], prev_reg.z};
        motion_sum = {2'b0, mag17(dx)} + {2'b0, mag17(dy)} + {2'b0, mag17(dz)};
        motion     = (motion_sum[17:16] != 2'b0) ? 16'hFFFF : motion_sum[15:0];

        rates_small = (mag16(smp.g.x) < cfg.rate_limit) &&
                      (mag16(smp.g.y) < cfg.rate_limit) &&
                      (mag16(smp.g.z) < cfg.rate_limit);
        still = sampled && (motion < cfg.motion_limit) && rates_small;

        // A rest start of zero means no rest period is running yet.
        rest_base       = (rest_start_reg == '0) ? smp.now : rest_start_reg;
        rest_elapsed    = smp.now - rest_base;
        long_rest       = rest_elapsed > cfg.rest_time_ms;
        rest_start_next = still ? rest_base : smp.now;

        capture = still && long_rest && !calibrated_reg;
        push    = still && long_rest && calibrated_reg;
        full    = fill_reg == CNT_W'(RING_DEPTH);

        widx_next = (widx_reg == IDX_W'(RING_DEPTH - 1)) ? '0 : widx_reg + IDX_W'(1);

        // Once the ring is full, the slot after the one just written is the oldest.
        ring_we    = fire && push;
        ring_waddr = widx_reg;
        ring_re    = fire && push && full;
        ring_raddr = widx_next;

        dec.sampled    = sampled;
        dec.still      = still;
        dec.calibrated = calibrated_reg || capture;
        dec.capture    = capture;
        dec.take_ring  = push && full;
        dec.g          = smp.g;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_accept_reg <= '0;
            rest_start_reg  <= '0;
            prev_reg        <= '0;
            calibrated_reg  <= 1'b0;
            widx_reg        <= '0;
            fill_reg        <= '0;
        end
        else if (fire && sampled)
        begin
            last_accept_reg <= smp.now;
            rest_start_reg  <= rest_start_next;
            prev_reg        <= smp.g;
            if (capture)
            begin
                calibrated_reg <= 1'b1;
            end
            if (push)
            begin
                widx_reg <= widx_next;
                if (!full)
                begin
                    fill_reg <= fill_reg + CNT_W'(1);
                end
            end
        end
    end

endmodule

@@ design/grbc_bias.sv @@
module grbc_bias
    import grbc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  decision_t dec,
    input  axes_t     ring_rdata,
    input  logic      fire,
    output result_t   res
);

    axes_t bias_reg;
    axes_t bias_next;

    always_comb
    begin
        if (dec.capture)
        begin
            bias_next = dec.g;
        end
        else if (dec.take_ring)
        begin
            bias_next = ring_rdata;
        end
        else
        begin
            bias_next = bias_reg;
        end

        res.sampled    = dec.sampled;
        res.still      = dec.still;
        res.calibrated = dec.calibrated;
        res.bias       = bias_next;
        if (dec.calibrated)
        begin
            res.rate.x = dec.g.x - bias_next.x;
            res.rate.y = dec.g.y - bias_next.y;
            res.rate.z = dec.g.z - bias_next.z;
        end
        else
        begin
            res.rate = dec.g;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bias_reg <= '0;
        end
        else if (fire)
        begin
            bias_reg <= bias_next;
        end
    end

endmodule

@@ design/gyro_rest_bias_calibrator.sv @@
// Gyro rest bias calibrator. Each accepted item is a three-axis gyro sample with a
// millisecond timestamp and yields exactly one result item, in order. The block takes
// one item per clock cycle when the output side keeps up. An accepted item passes
// through the input stage, then the bias stage, then the output register. The rest
// ring lives in a simple dual-port RAM with a registered read: an item pushed in the
// input stage writes its slot and, once the ring is full, reads the oldest slot; the
// bias stage uses the registered read data, which holds while that stage stalls. The
// ring needs no clearing pass after reset, so items are taken right away. The user
// must write configuration registers through the cfg port only while no item is in
// flight; the block itself does not enforce this. cfg_ready is always high.
module gyro_rest_bias_calibrator
    import grbc_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF,
    localparam int IDX_W = $clog2(RING_DEPTH)
) (
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [GYRO_W-1:0] gyro_x,
    input  logic signed [GYRO_W-1:0] gyro_y,
    input  logic signed [GYRO_W-1:0] gyro_z,
    input  logic [TIME_W-1:0]        time_ms,

    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     sampled,
    output logic                     still,
    output logic                     calibrated,
    output logic signed [GYRO_W-1:0] bias_x,
    output logic signed [GYRO_W-1:0] bias_y,
    output logic signed [GYRO_W-1:0] bias_z,
    output logic signed [GYRO_W-1:0] rate_x,
    output logic signed [GYRO_W-1:0] rate_y,
    output logic signed [GYRO_W-1:0] rate_z,

    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_INDEX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data
);

    cfg_t      cfg_reg;
    logic      a_valid_reg;
    sample_t   a_smp_reg;
    logic      b_valid_reg;
    decision_t b_dec_reg;
    logic      out_valid_reg;
    result_t   out_res_reg;

    logic      a_adv;
    logic      b_adv;
    logic      fire_a;
    logic      fire_b;
    decision_t dec;
    result_t   res;
    axes_t     ring_rdata;
    logic      ring_we;
    logic      ring_re;
    logic [IDX_W-1:0] ring_waddr;
    logic [IDX_W-1:0] ring_raddr;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.decimate_ms  <= DECIMATE_RST;
            cfg_reg.motion_limit <= MOTION_RST;
            cfg_reg.rate_limit   <= RATE_RST;
            cfg_reg.rest_time_ms <= REST_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_DECIMATE: cfg_reg.decimate_ms  <= cfg_data[15:0];
                CFG_MOTION:   cfg_reg.motion_limit <= cfg_data[15:0];
                CFG_RATE:     cfg_reg.rate_limit   <= cfg_data[15:0];
                CFG_REST:     cfg_reg.rest_time_ms <= cfg_data;
                default:      ;
            endcase
        end
    end

    // Each stage moves on when the stage after it is empty or moving on too.
    assign b_adv    = !out_valid_reg || out_ready;
    assign a_adv    = !b_valid_reg || b_adv;
    assign in_ready = !a_valid_reg || a_adv;
    assign fire_a   = a_valid_reg && a_adv;
    assign fire_b   = b_valid_reg && b_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                a_valid_reg <= in_valid;
            end
            if (a_adv)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (b_adv)
            begin
                out_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            a_smp_reg.g.x <= gyro_x;
            a_smp_reg.g.y <= gyro_y;
            a_smp_reg.g.z <= gyro_z;
            a_smp_reg.now <= time_ms;
        end
        if (fire_a)
        begin
            b_dec_reg <= dec;
        end
        if (fire_b)
        begin
            out_res_reg <= res;
        end
    end

    grbc_detect #(
        .RING_DEPTH (RING_DEPTH)
    ) u_detect (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .smp        (a_smp_reg),
        .fire       (fire_a),
        .dec        (dec),
        .ring_we    (ring_we),
        .ring_waddr (ring_waddr),
        .ring_re    (ring_re),
        .ring_raddr (ring_raddr)
    );

    grbc_ram #(
        .WIDTH ($bits(axes_t)),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ring_we),
        .waddr (ring_waddr),
        .wdata (dec.g),
        .re    (ring_re),
        .raddr (ring_raddr),
        .rdata (ring_rdata)
    );

    grbc_bias u_bias (
        .clk        (clk),
        .rst_n      (rst_n),
        .dec        (b_dec_reg),
        .ring_rdata (ring_rdata),
        .fire       (fire_b),
        .res        (res)
    );

    assign out_valid  = out_valid_reg;
    assign sampled    = out_res_reg.sampled;
    assign still      = out_res_reg.still;
    assign calibrated = out_res_reg.calibrated;
    assign bias_x     = out_res_reg.bias.x;
    assign bias_y     = out_res_reg.bias.y;
    assign bias_z     = out_res_reg.bias.z;
    assign rate_x     = out_res_reg.rate.x;
    assign rate_y     = out_res_reg.rate.y;
    assign rate_z     = out_res_reg.rate.z;

endmodule
